[design/cat_pkg.sv]
// shared types, constants and helpers for the calendar alarm table
package cat_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int ENTRY_W  = 34;

	localparam logic       OP_ADD   = 1'b0;
	localparam logic       OP_CHECK = 1'b1;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BAD_DATE = 3'd2;
	localparam logic [2:0] ST_BAD_TIME = 3'd3;
	localparam logic [2:0] ST_MATCH    = 3'd4;
	localparam logic [2:0] ST_NONE     = 3'd5;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] LEAP_FEB  = 5'd29;
	localparam logic [4:0] MAX_HOUR  = 5'd23;
	localparam logic [5:0] MAX_MIN   = 6'd59;

	// reciprocal of 100 for a 14-bit year: q = (y * 5243) >> 19
	localparam int          RECIP_W     = 27;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [26:0] RECIP_100   = 27'd5243;
	localparam logic [13:0] CENTURY     = 14'd100;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} entry_t;

	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[design/cat_ram.sv]
// generic single-write, single-read ram with registered read data
module cat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/calendar_alarm_table.sv]
// calendar alarm table top level: add and check sequencer over the entry ram
//
// Input channel (in_valid / in_stall) carries one item: opcode, day, month,
// year, hour, minute. Output channel (out_valid / out_stall) carries results:
// status, entry_index, last. Both transfer when valid is high and stall is low.
// An add item gives one status result through the year-by-100 reciprocal
// multiply, then the date, time and fill checks plus the ram write, then the
// load of the output register.
// A check item reads the entry ram once per cycle through one compare unit
// while no stalled receiver holds back a further match; each match is held
// until the next match or the scan end so that the final one can carry last.
// The block takes no new item until the previous one has loaded its final
// result into the output register; that result may still be waiting.
// A stalled receiver holds the output register, which in turn pauses the
// scan whenever a further match must be sent.
// Reset clears the fill count and all control state; the table contents stay
// undefined and are only read below the fill count.
module calendar_alarm_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  entry_index,
	output logic        last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]                    state_q;
	logic [cat_pkg::COUNT_W-1:0]   count_q;
	logic [cat_pkg::IDX_W-1:0]     idx_q;
	logic                          pend_q;
	logic                          out_valid_q;

	cat_pkg::entry_t               cur_q;
	logic [7:0]                    quo_q;
	logic [cat_pkg::IDX_W-1:0]     pend_idx_q;
	logic [2:0]                    res_status_q;
	logic [cat_pkg::IDX_W-1:0]     res_index_q;
	logic [2:0]                    status_q;
	logic [cat_pkg::IDX_W-1:0]     index_q;
	logic                          last_q;

	logic                          in_acc;
	logic                          out_free;
	logic [cat_pkg::RECIP_W-1:0]   prod;
	logic [13:0]                   rem100;
	logic                          leap;
	logic [4:0]                    lim;
	logic                          full;
	logic                          date_ok;
	logic                          time_ok;
	logic [2:0]                    add_status;
	logic                          ram_we;
	logic [cat_pkg::ENTRY_W-1:0]   ram_rdata;
	logic [cat_pkg::IDX_W-1:0]     rd_addr;
	cat_pkg::entry_t               rd_entry;
	logic                          hit;
	logic                          scan_last;
	logic                          scan_hold;
	logic                          scan_emit;
	logic                          out_load;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// leap year from the registered quotient of year / 100
	assign prod    = cat_pkg::RECIP_W'(cur_q.year) * cat_pkg::RECIP_100;
	assign rem100  = cur_q.year - 14'({6'd0, quo_q} * cat_pkg::CENTURY);
	assign leap    = ((cur_q.year[1:0] == 2'd0) && (rem100 != 14'd0)) ||
	                 ((rem100 == 14'd0) && (quo_q[1:0] == 2'd0));
	assign lim     = (cur_q.month == cat_pkg::MONTH_FEB && leap) ? cat_pkg::LEAP_FEB
	                 : cat_pkg::month_days(cur_q.month);
	assign full    = (count_q >= cat_pkg::COUNT_W'(cat_pkg::CAPACITY));
	assign date_ok = (cur_q.month != 4'd0) && (cur_q.month <= cat_pkg::MONTH_DEC) &&
	                 (cur_q.day != 5'd0) && (cur_q.day <= lim);
	assign time_ok = (cur_q.hour <= cat_pkg::MAX_HOUR) && (cur_q.minute <= cat_pkg::MAX_MIN);

	always_comb begin
		if (full) begin
			add_status = cat_pkg::ST_FULL;
		end else if (!date_ok) begin
			add_status = cat_pkg::ST_BAD_DATE;
		end else if (!time_ok) begin
			add_status = cat_pkg::ST_BAD_TIME;
		end else begin
			add_status = cat_pkg::ST_ADDED;
		end
	end

	assign ram_we = (state_q == S_CHK) && (add_status == cat_pkg::ST_ADDED);

	// shared compare unit for the scan
	assign rd_entry  = cat_pkg::entry_t'(ram_rdata);
	assign hit       = (rd_entry.day == cur_q.day) && (rd_entry.month == cur_q.month) &&
	                   (rd_entry.year == cur_q.year) && (rd_entry.hour == cur_q.hour) &&
	                   ((rd_entry.minute == cur_q.minute) ||
	                    ({1'b0, rd_entry.minute} + 7'd1 == {1'b0, cur_q.minute}) ||
	                    ({1'b0, rd_entry.minute} == {1'b0, cur_q.minute} + 7'd1));
	assign scan_last = ({1'b0, idx_q} + cat_pkg::COUNT_W'(1)) == count_q;
	assign scan_hold = hit && pend_q && !out_free;
	assign scan_emit = (state_q == S_SCAN) && hit && pend_q && out_free;
	assign out_load  = scan_emit || ((state_q == S_EMIT) && out_free);

	always_comb begin
		if (state_q == S_SCAN) begin
			rd_addr = scan_hold ? idx_q : idx_q + cat_pkg::IDX_W'(1);
		end else begin
			rd_addr = '0;
		end
	end

	cat_ram #(
		.WIDTH(cat_pkg::ENTRY_W),
		.DEPTH(cat_pkg::CAPACITY),
		.AW   (cat_pkg::IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[cat_pkg::IDX_W-1:0]),
		.wdata(cur_q),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (opcode == cat_pkg::OP_ADD) begin
							state_q <= S_DIV;
						end else if (count_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
							idx_q   <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				S_DIV: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (ram_we) begin
						count_q <= count_q + cat_pkg::COUNT_W'(1);
					end
					state_q <= S_EMIT;
				end
				S_SCAN: begin
					if (!scan_hold) begin
						if (hit) begin
							pend_q <= 1'b1;
						end
						if (scan_last) begin
							state_q <= S_EMIT;
						end else begin
							idx_q <= idx_q + cat_pkg::IDX_W'(1);
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q        <= '{day: day, month: month, year: year, hour: hour, minute: minute};
			res_status_q <= cat_pkg::ST_NONE;
			res_index_q  <= '0;
		end
		if (state_q == S_DIV) begin
			quo_q <= prod[cat_pkg::RECIP_SHIFT +: 8];
		end
		if (state_q == S_CHK) begin
			res_status_q <= add_status;
			res_index_q  <= ram_we ? count_q[cat_pkg::IDX_W-1:0] : '0;
		end
		if ((state_q == S_SCAN) && !scan_hold) begin
			if (hit) begin
				pend_idx_q <= idx_q;
			end
			if (scan_last) begin
				res_status_q <= (hit || pend_q) ? cat_pkg::ST_MATCH : cat_pkg::ST_NONE;
				res_index_q  <= hit ? idx_q : (pend_q ? pend_idx_q : '0);
			end
		end
		if (scan_emit) begin
			status_q <= cat_pkg::ST_MATCH;
			index_q  <= pend_idx_q;
			last_q   <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			status_q <= res_status_q;
			index_q  <= res_index_q;
			last_q   <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign last        = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cat_pkg::COUNT_W'(cat_pkg::CAPACITY))
		else $error("fill count above capacity");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < cat_pkg::COUNT_W'(cat_pkg::CAPACITY)))
		else $error("entry write with table full");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ({1'b0, idx_q} < count_q))
		else $error("scan index beyond fill count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("output register loaded while result stalled");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && out_free) |=> (out_valid_q && last_q))
		else $error("final result not flagged last");

endmodule

[dv/calendar_alarm_table_tb.sv]
// testbench for calendar_alarm_table: directed table plus random adds and checks against a predictor
module calendar_alarm_table_tb;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_REPORTED = 10;
	localparam int HOT_KEYS     = 4;

	typedef struct packed {
		logic        op;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [4:0]  h;
		logic [5:0]  mi;
		logic        typed;
		logic [2:0]  tstat;
		logic [5:0]  tidx;
	} stim_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] idx;
		logic       last;
	} alarm_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [4:0]  day;
	logic [3:0]  month;
	logic [13:0] year;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [5:0]  entry_index;
	logic        last;

	cat_pkg::entry_t alarm_tab [cat_pkg::CAPACITY];
	int              alarm_fill;
	alarm_result_t   pending_results [$];
	stim_t           dir_rows [$];
	stim_t           hot_keys [HOT_KEYS];
	int              mismatches = 0;
	int              cycle_count = 0;
	int              send_pct;
	int              recv_pct;

	calendar_alarm_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.day         (day),
		.month       (month),
		.year        (year),
		.hour        (hour),
		.minute      (minute),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_index (entry_index),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("calendar_alarm_table verification failed");
		$finish;
	end

	function automatic bit is_leap(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_span(input int m, input int y);
		int len;
		case (m)
			4, 6, 9, 11: len = 30;
			2:           len = is_leap(y) ? 29 : 28;
			default:     len = 31;
		endcase
		return len;
	endfunction

	function automatic stim_t row(input logic op, input int d, input int m, input int y,
			input int h, input int mi);
		stim_t s;
		s       = '0;
		s.op    = op;
		s.d     = d[4:0];
		s.m     = m[3:0];
		s.y     = y[13:0];
		s.h     = h[4:0];
		s.mi    = mi[5:0];
		return s;
	endfunction

	function automatic stim_t with_result(input stim_t s, input logic [2:0] st,
			input int idx);
		stim_t t;
		t       = s;
		t.typed = 1'b1;
		t.tstat = st;
		t.tidx  = idx[5:0];
		return t;
	endfunction

	function automatic stim_t valid_add();
		int m;
		int y;
		m = $urandom_range(12, 1);
		y = ($urandom_range(9) == 0) ? $urandom_range(16383, 10000) : $urandom_range(9999);
		return row(cat_pkg::OP_ADD, $urandom_range(month_span(m, y), 1), m, y,
			$urandom_range(23), $urandom_range(59));
	endfunction

	function automatic stim_t hot_item(input logic op);
		stim_t s;
		int    mi;
		s    = hot_keys[$urandom_range(HOT_KEYS - 1)];
		s.op = op;
		if (op == cat_pkg::OP_ADD) begin
			mi = int'(s.mi) + $urandom_range(2) - 1;
			mi = (mi < 0) ? 0 : ((mi > 59) ? 59 : mi);
		end else begin
			mi = int'(s.mi) + $urandom_range(4) - 2;
			mi = (mi < 0) ? 0 : mi;
		end
		s.mi = mi[5:0];
		return s;
	endfunction

	function automatic stim_t random_item();
		int sel;
		sel = $urandom_range(99);
		if (sel < 45)
			return hot_item(cat_pkg::OP_ADD);
		else if (sel < 55)
			return valid_add();
		else if (sel < 80)
			return hot_item(cat_pkg::OP_CHECK);
		else
			return row(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
				$urandom);
	endfunction

	function automatic void predict_alarm_results(input stim_t s);
		alarm_result_t r;
		alarm_result_t held;
		bit            have_held;
		bit            date_good;
		int            smi;
		int            cmi;
		r         = '0;
		held      = '0;
		have_held = 1'b0;
		if (s.op == cat_pkg::OP_ADD) begin
			r.last    = 1'b1;
			date_good = (s.m >= 1) && (s.m <= cat_pkg::MONTH_DEC) && (s.d >= 1) &&
				(int'(s.d) <= month_span(s.m, s.y));
			if (alarm_fill >= cat_pkg::CAPACITY) begin
				r.status = cat_pkg::ST_FULL;
			end else if (!date_good) begin
				r.status = cat_pkg::ST_BAD_DATE;
			end else if (s.h > cat_pkg::MAX_HOUR || s.mi > cat_pkg::MAX_MIN) begin
				r.status = cat_pkg::ST_BAD_TIME;
			end else begin
				r.status = cat_pkg::ST_ADDED;
				r.idx    = alarm_fill[5:0];
				alarm_tab[alarm_fill] = '{day: s.d, month: s.m, year: s.y,
					hour: s.h, minute: s.mi};
				alarm_fill++;
			end
			pending_results.push_back(r);
		end else begin
			cmi = s.mi;
			for (int i = 0; i < alarm_fill; i++) begin
				smi = alarm_tab[i].minute;
				if (alarm_tab[i].day == s.d && alarm_tab[i].month == s.m &&
						alarm_tab[i].year == s.y && alarm_tab[i].hour == s.h &&
						(smi == cmi || smi + 1 == cmi || smi == cmi + 1)) begin
					if (have_held)
						pending_results.push_back(held);
					held      = '{status: cat_pkg::ST_MATCH, idx: i[5:0], last: 1'b0};
					have_held = 1'b1;
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				pending_results.push_back(held);
			end else begin
				r.status = cat_pkg::ST_NONE;
				r.last   = 1'b1;
				pending_results.push_back(r);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input alarm_result_t e,
			input alarm_result_t a);
		mismatches++;
		if (mismatches <= MAX_REPORTED)
			$display("mismatch (%s) at cycle %0d: expected status %0d index %0d last %0b,",
				what, cycle_count, e.status, e.idx, e.last,
				" got status %0d index %0d last %0b", a.status, a.idx, a.last);
	endtask

	// each call starts and ends at a falling edge
	task automatic drive_item(input stim_t s);
		alarm_result_t r;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= s.op;
		day      <= s.d;
		month    <= s.m;
		year     <= s.y;
		hour     <= s.h;
		minute   <= s.mi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_alarm_results(s);
		if (s.typed) begin
			void'(pending_results.pop_back());
			r = '{status: s.tstat, idx: s.tidx, last: 1'b1};
			pending_results.push_back(r);
		end
		@(negedge clk);
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		alarm_result_t got;
		alarm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status: status, idx: entry_index, last: last};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.idx !== want.idx ||
						got.last !== want.last)
					report_mismatch("wrong field", want, got);
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		opcode     <= cat_pkg::OP_ADD;
		day        <= '0;
		month      <= '0;
		year       <= '0;
		hour       <= '0;
		minute     <= '0;
		alarm_fill = 0;
		send_pct   = 0;
		recv_pct   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		dir_rows.push_back(with_result(row(cat_pkg::OP_CHECK, 1, 1, 2000, 0, 0),
			cat_pkg::ST_NONE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 1, 0, 2000, 0, 0),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 1, 13, 2000, 0, 0),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 31, 15, 16383, 31, 63),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 0, 1, 2000, 0, 0),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 29, 2, 1900, 0, 0),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 29, 2, 2023, 0, 0),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 31, 4, 2021, 0, 0),
			cat_pkg::ST_BAD_DATE, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 1, 1, 2000, 24, 0),
			cat_pkg::ST_BAD_TIME, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 1, 1, 2000, 0, 60),
			cat_pkg::ST_BAD_TIME, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 29, 2, 2000, 23, 59),
			cat_pkg::ST_ADDED, 0));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 29, 2, 0, 0, 0),
			cat_pkg::ST_ADDED, 1));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 29, 2, 2024, 12, 30),
			cat_pkg::ST_ADDED, 2));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 31, 12, 9999, 23, 59),
			cat_pkg::ST_ADDED, 3));
		dir_rows.push_back(with_result(row(cat_pkg::OP_ADD, 29, 2, 10000, 5, 1),
			cat_pkg::ST_ADDED, 4));
		dir_rows.push_back(row(cat_pkg::OP_ADD, 29, 2, 2000, 23, 58));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 2000, 23, 59));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 2000, 23, 60));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 2000, 23, 57));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 2000, 23, 63));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 2000, 22, 59));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 0, 0, 0));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 0, 0, 1));
		dir_rows.push_back(with_result(row(cat_pkg::OP_CHECK, 29, 2, 0, 0, 2),
			cat_pkg::ST_NONE, 0));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 31, 12, 9999, 23, 58));
		dir_rows.push_back(row(cat_pkg::OP_CHECK, 29, 2, 10000, 5, 0));
		foreach (dir_rows[i])
			drive_item(dir_rows[i]);

		// hour edges on two keys so the minute window is exercised at 0 and 59
		hot_keys[0] = row(cat_pkg::OP_ADD, 29, 2, 2000, 23, 59);
		hot_keys[1] = row(cat_pkg::OP_ADD, 1, 1, 0, 0, 0);
		for (int k = 2; k < HOT_KEYS; k++)
			hot_keys[k] = valid_add();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 83; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 83; end
				default: begin send_pct = 31; recv_pct = 31; end
			endcase
			repeat (15) drive_item(random_item());
		end

		// fill the table, then hit it while full
		while (alarm_fill < cat_pkg::CAPACITY)
			drive_item(hot_item(cat_pkg::OP_ADD));
		drive_item(with_result(hot_item(cat_pkg::OP_ADD), cat_pkg::ST_FULL, 0));
		drive_item(with_result(row(cat_pkg::OP_ADD, 29, 2, 1900, 0, 0), cat_pkg::ST_FULL, 0));
		drive_item(with_result(row(cat_pkg::OP_ADD, 1, 1, 2000, 31, 63), cat_pkg::ST_FULL, 0));
		repeat (6) drive_item(hot_item(cat_pkg::OP_CHECK));
		drive_item(row(cat_pkg::OP_CHECK, 31, 15, 16383, 31, 63));

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (cat_pkg::CAPACITY + 16) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("calendar_alarm_table verification clean");
		end else begin
			$display("calendar_alarm_table verification failed");
		end
		$finish;
	end

endmodule
